>>> hw/rtl/mreq_pkg.sv
// Shared types and constants for the multi-reader event queue.
// Used by the controller, the datapath, the top level and the port checker.
// Has no dependencies of its own.
package mreq_pkg;

  localparam int REQ_W    = 3;
  localparam int RID_W    = 3;
  localparam int TYPE_W   = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int EVENT_W  = TYPE_W + DATA_W;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_PUSH  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_OPEN  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLOSE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOSLOT = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the request, clear the scan state
    logic scan_step;  // examine one reader slot for the clean minimum
    logic clean;      // drop head events and rebase the offsets
    logic issue;      // carry out the request, launch the memory read
    logic finish;     // load the result registers
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // the slot under examination is the last one
  } stat_t;

endpackage

>>> hw/rtl/multi_reader_event_queue.sv
// Top level of the multi-reader event queue: a shared event FIFO with
// independent reader offsets. Depends on mreq_pkg, mreq_ctrl, mreq_datapath.
//
// Usage. A request beat is taken at a rising edge where start is high and
// busy is low; req_type selects push, pop, open, close or read, reader_id
// names the slot for close and read, event_type and event_data carry the
// event to push. Every request yields exactly one result beat: done is high
// for one cycle while status, reader_out, type_out and data_out hold the
// result. The receiver cannot stall, so the result is taken in that cycle.
//
// Timing. Push, pop, open and close pass through the issue state and the
// finish state; busy stays high until done rises and drops with it, so a
// new request is not taken before the previous result is shown.
// A read first scans the reader slots one per cycle to find the smallest
// active offset, then passes through a clean state that drops head events
// and rebases the offsets, the issue state with the event memory read, and
// the finish state.
//
// Reset (rst, synchronous) empties the queue, clears the head pointer and
// marks every reader slot inactive. The event memory is not cleared; only
// entries written by a push are ever returned.
module multi_reader_event_queue #(
  parameter int QUEUE_DEPTH = 64,
  parameter int READERS     = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mreq_pkg::REQ_W-1:0]    req_type,
  input  logic [mreq_pkg::RID_W-1:0]    reader_id,
  input  logic [mreq_pkg::TYPE_W-1:0]   event_type,
  input  logic [mreq_pkg::DATA_W-1:0]   event_data,
  output logic                          done,
  output logic [mreq_pkg::STATUS_W-1:0] status,
  output logic [mreq_pkg::RID_W-1:0]    reader_out,
  output logic [mreq_pkg::TYPE_W-1:0]   type_out,
  output logic [mreq_pkg::DATA_W-1:0]   data_out
);
  import mreq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller only sequences; all queue state lives in the datapath.
  mreq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // The datapath captures the request beat on cmd.latch, which the
  // controller raises only when the beat is accepted.
  mreq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .READERS     (READERS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req_type),
    .reader_id  (reader_id),
    .event_type (event_type),
    .event_data (event_data),
    .done       (done),
    .status     (status),
    .reader_out (reader_out),
    .type_out   (type_out),
    .data_out   (data_out)
  );

endmodule

>>> hw/rtl/mreq_ctrl.sv
// Sequencing state machine of the multi-reader event queue.
// Depends on mreq_pkg for the request codes and the command and status structs.
module mreq_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [mreq_pkg::REQ_W-1:0] req_type,
  input  mreq_pkg::stat_t          stat,
  output mreq_pkg::cmd_t           cmd,
  output logic                     busy
);
  import mreq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLEAN,
    S_ISSUE,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= (req_type == REQ_READ) ? S_SCAN : S_ISSUE;
          end
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_CLEAN;
          end
        end
        S_CLEAN:  state <= S_ISSUE;
        S_ISSUE:  state <= S_FINISH;
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:   cmd.latch     = start;
      S_SCAN:   cmd.scan_step = 1'b1;
      S_CLEAN:  cmd.clean     = 1'b1;
      S_ISSUE:  cmd.issue     = 1'b1;
      S_FINISH: cmd.finish    = 1'b1;
      default:  cmd = '0;
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

>>> hw/rtl/mreq_datapath.sv
// Datapath of the multi-reader event queue: event memory, queue pointers,
// reader slots, clean-minimum scan and result registers. Depends on mreq_pkg.
module mreq_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int READERS     = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mreq_pkg::cmd_t                cmd,
  output mreq_pkg::stat_t               stat,
  input  logic [mreq_pkg::REQ_W-1:0]    req_type,
  input  logic [mreq_pkg::RID_W-1:0]    reader_id,
  input  logic [mreq_pkg::TYPE_W-1:0]   event_type,
  input  logic [mreq_pkg::DATA_W-1:0]   event_data,
  output logic                          done,
  output logic [mreq_pkg::STATUS_W-1:0] status,
  output logic [mreq_pkg::RID_W-1:0]    reader_out,
  output logic [mreq_pkg::TYPE_W-1:0]   type_out,
  output logic [mreq_pkg::DATA_W-1:0]   data_out
);
  import mreq_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int IDX_W = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int SEL_W = (IDX_W > RID_W) ? IDX_W : RID_W;
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(READERS - 1);

  // Latched request.
  logic [REQ_W-1:0]  req_q;
  logic [RID_W-1:0]  rid_q;
  logic [TYPE_W-1:0] etype_q;
  logic [DATA_W-1:0] edata_q;

  // Queue and reader state.
  logic [PTR_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] offset [READERS];
  logic             active [READERS];

  // Clean-minimum scan state.
  logic [IDX_W-1:0] scan_idx;
  logic             any_act;
  logic             zero_seen;
  logic [CNT_W-1:0] low;

  // Pending result.
  logic [STATUS_W-1:0] st_q;
  logic [RID_W-1:0]    rout_q;
  logic                use_mem;

  logic [EVENT_W-1:0] mem [QUEUE_DEPTH];
  logic [EVENT_W-1:0] rd_q;

  logic [SEL_W-1:0]   sel_idx;
  logic [READERS-1:0] hit;
  logic               sel_act;
  logic [CNT_W-1:0]   sel_off;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               full;
  logic               empty;
  logic               read_ok;
  logic               do_clean;
  logic [CNT_W-1:0]   drop_n;
  logic [PTR_W-1:0]   wr_addr;
  logic [PTR_W-1:0]   rd_addr;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(n);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[PTR_W-1:0];
  endfunction

  // One slot-select mux on the slot registers, shared by the scan and the request.
  assign sel_idx = cmd.scan_step ? SEL_W'(scan_idx) : SEL_W'(rid_q);

  always_comb begin
    sel_act    = 1'b0;
    sel_off    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < READERS; i++) begin
      hit[i] = (sel_idx == SEL_W'(i));
      if (hit[i]) begin
        sel_act = active[i];
        sel_off = offset[i];
      end
    end
    for (int i = READERS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign full     = (count == DEPTH_C);
  assign empty    = (count == '0);
  assign read_ok  = sel_act && (sel_off < count);
  assign do_clean = any_act && !zero_seen;
  assign drop_n   = (low > count) ? count : low;
  assign wr_addr  = wrap_add(head, count);
  assign rd_addr  = (req_q == REQ_POP) ? head : wrap_add(head, sel_off);

  assign stat.scan_last = (scan_idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q   <= req_type;
      rid_q   <= reader_id;
      etype_q <= event_type;
      edata_q <= event_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      any_act   <= 1'b0;
      zero_seen <= 1'b0;
      low       <= '0;
    end else if (cmd.latch) begin
      scan_idx  <= '0;
      any_act   <= 1'b0;
      zero_seen <= 1'b0;
      low       <= '0;
    end else if (cmd.scan_step) begin
      if (!stat.scan_last) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (sel_act) begin
        any_act <= 1'b1;
        if (sel_off == '0) begin
          zero_seen <= 1'b1;
        end
        if (!any_act || sel_off < low) begin
          low <= sel_off;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      st_q    <= ST_OK;
      rout_q  <= '0;
      use_mem <= 1'b0;
      for (int i = 0; i < READERS; i++) begin
        offset[i] <= '0;
        active[i] <= 1'b0;
      end
    end else if (cmd.clean) begin
      if (do_clean) begin
        head  <= wrap_add(head, drop_n);
        count <= count - drop_n;
        for (int i = 0; i < READERS; i++) begin
          if (active[i]) begin
            offset[i] <= offset[i] - low;
          end
        end
      end
    end else if (cmd.issue) begin
      st_q    <= ST_OK;
      rout_q  <= '0;
      use_mem <= 1'b0;
      unique case (req_q)
        REQ_PUSH: begin
          if (full) begin
            st_q <= ST_FULL;
          end else begin
            count <= count + CNT_W'(1);
          end
        end
        REQ_POP: begin
          if (empty) begin
            st_q <= ST_EMPTY;
          end else begin
            use_mem <= 1'b1;
            head    <= wrap_add(head, CNT_W'(1));
            count   <= count - CNT_W'(1);
          end
        end
        REQ_OPEN: begin
          if (free_found) begin
            active[free_idx] <= 1'b1;
            offset[free_idx] <= '0;
            rout_q           <= RID_W'(free_idx);
          end else begin
            st_q <= ST_NOSLOT;
          end
        end
        REQ_CLOSE: begin
          for (int i = 0; i < READERS; i++) begin
            if (hit[i]) begin
              active[i] <= 1'b0;
            end
          end
        end
        REQ_READ: begin
          if (read_ok) begin
            use_mem <= 1'b1;
            for (int i = 0; i < READERS; i++) begin
              if (hit[i]) begin
                offset[i] <= offset[i] + CNT_W'(1);
              end
            end
          end else begin
            st_q <= ST_EMPTY;
          end
        end
        default: begin
          st_q <= ST_OK;
        end
      endcase
    end
  end

  // Event memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.issue && (req_q == REQ_PUSH) && !full) begin
      mem[wr_addr] <= {etype_q, edata_q};
    end
    if (cmd.issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status     <= st_q;
      reader_out <= rout_q;
      type_out   <= use_mem ? rd_q[EVENT_W-1:DATA_W] : '0;
      data_out   <= use_mem ? rd_q[DATA_W-1:0] : '0;
    end
  end

endmodule

>>> hw/rtl/mreq_checker.sv
// Port-level checks for the multi-reader event queue, bound to the top level.
// Depends on mreq_pkg and multi_reader_event_queue.
module mreq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [mreq_pkg::STATUS_W-1:0] status,
  input logic [mreq_pkg::TYPE_W-1:0]   type_out,
  input logic [mreq_pkg::DATA_W-1:0]   data_out
);
  import mreq_pkg::*;

  // A result beat is shown only once the request is finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while busy");

  // An accepted request always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not start work");

  // Every result beat follows a cycle of work.
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result beat without a request");

  // A failed request returns no event.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((type_out == '0) && (data_out == '0)))
    else $error("event returned with a failing status");

endmodule

bind multi_reader_event_queue mreq_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .type_out (type_out),
  .data_out (data_out)
);
